// ----- hdl/btda_pkg.sv -----
// Package for the binary to decimal ASCII converter.
// Holds shared widths, constants, the add-3 adjust function and the stage-to-stage item type.
package btda_pkg;
    localparam int BIN_W   = 32;
    localparam int NDIG    = 10;
    localparam int BCD_W   = NDIG * 4;
    localparam int CHAR_W  = 6;
    localparam int CNT_W   = 4;
    localparam int STAGES  = 4;
    localparam int BITS_PER_STAGE = BIN_W / STAGES;
    localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [BCD_W-1:0] bcd;
    } t_dd;

    function automatic logic [BCD_W-1:0] f_adj(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int i = 0; i < NDIG; i++) begin
            if (b[i*4 +: 4] > 4'd4) begin
                r[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
            end
        end
        return r;
    endfunction
endpackage

// ----- hdl/btda_stage.sv -----
// One double-dabble pipeline stage: BITS_PER_STAGE shift-add-3 steps.
// Depends on btda_pkg.
module btda_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  btda_pkg::t_dd    i_dd,
    output logic             o_valid,
    output btda_pkg::t_dd    o_dd
);
    btda_pkg::t_dd n_dd;
    btda_pkg::t_dd r_dd;
    logic          r_valid;

    always_comb begin
        n_dd = i_dd;
        for (int s = 0; s < btda_pkg::BITS_PER_STAGE; s++) begin
            n_dd.bcd = btda_pkg::f_adj(n_dd.bcd);
            n_dd.bcd = {n_dd.bcd[btda_pkg::BCD_W-2:0], n_dd.bin[btda_pkg::BIN_W-1]};
            n_dd.bin = {n_dd.bin[btda_pkg::BIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_dd <= n_dd;
        end
    end

    assign o_valid = r_valid;
    assign o_dd    = r_dd;
endmodule

// ----- hdl/btda_emit.sv -----
// Digit emitter: leading-zero skip and MSD-first character output.
// Depends on btda_pkg.
module btda_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [btda_pkg::BCD_W-1:0]    i_bcd,
    output logic                          o_ready,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata,
    output logic                          m_axis_tlast
);
    logic [btda_pkg::BCD_W-1:0] r_bcd;
    logic [btda_pkg::CNT_W-1:0] r_idx;
    logic                       r_busy;
    logic [btda_pkg::CNT_W-1:0] n_top;
    logic                       w_take;

    always_comb begin
        n_top = '0;
        for (int i = 0; i < btda_pkg::NDIG; i++) begin
            if (i_bcd[i*4 +: 4] != 4'd0) begin
                n_top = btda_pkg::CNT_W'(i);
            end
        end
    end

    assign o_ready = !r_busy || (m_axis_tready && r_idx == '0);
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_take) begin
            r_busy <= 1'b1;
        end else if (r_busy && m_axis_tready && r_idx == '0) begin
            r_busy <= 1'b0;
        end
        if (w_take) begin
            r_bcd <= i_bcd;
            r_idx <= n_top;
        end else if (r_busy && m_axis_tready && r_idx != '0) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tlast  = (r_idx == '0);
    assign m_axis_tdata  = {2'b00, btda_pkg::DIGIT_BASE
                           + {2'b00, r_bcd[r_idx*4 +: 4]}};

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> r_idx == '0)
        else $error("last without index zero");
    a_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_bcd[r_idx*4 +: 4] <= 4'd9)
        else $error("non-decimal digit");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(r_idx))
        else $error("index moved under stall");
endmodule

// ----- hdl/binary_to_decimal_ascii.sv -----
// Binary to decimal ASCII converter, top level.
// Conversion: 4 pipeline stages of 8 double-dabble steps, then the emitter registers the value.
// The emitter sends one character per cycle while m_axis_tready is high, 1 to 10 characters per value.
// The conversion pipeline accepts one value a cycle and stalls behind the emitter.
// Reset (i_rst_n, synchronous, active low) clears all valid bits; data is not reset.
// Depends on btda_pkg, btda_stage, btda_emit.
module binary_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] digit_char
    output logic        m_axis_tlast    // last_digit
);
    localparam int N = btda_pkg::STAGES;
    btda_pkg::t_dd   w_dd [N+1];
    logic            w_v  [N+1];
    logic            w_emit_ready;
    logic            w_en;

    assign w_en          = w_emit_ready || !w_v[N];
    assign s_axis_tready = w_en;
    assign w_v[0]        = s_axis_tvalid;
    assign w_dd[0].bin   = s_axis_tdata;
    assign w_dd[0].bcd   = '0;

    for (genvar g = 0; g < N; g++) begin : g_stage
        btda_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_dd    (w_dd[g]),
            .o_valid (w_v[g+1]),
            .o_dd    (w_dd[g+1])
        );
    end

    btda_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_v[N]),
        .i_bcd         (w_dd[N].bcd),
        .o_ready       (w_emit_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );
endmodule

// ----- tb/tb_binary_to_decimal_ascii.sv -----
// Testbench for binary_to_decimal_ascii: drives 32-bit values over the input stream
// and checks each ASCII digit transfer against a local decimal conversion.
// Depends on btda_pkg and binary_to_decimal_ascii.
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [btda_pkg::CHAR_W-1:0] digit_char;
        logic                        last_digit;
    } t_digit;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [5:0] digit_char
    logic        m_axis_tlast;   // last_digit

    t_digit digit_queue[$];
    int     mismatches;
    int     idle_cycles;
    bit     gaps_on;
    bit     timed_out;

    binary_to_decimal_ascii uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Push the decimal digits of a value, most significant first.
    function automatic void predict_digits(input logic [31:0] value);
        logic [3:0] rev [btda_pkg::NDIG];
        int         count;
        logic [31:0] v;
        t_digit     d;
        v = value;
        count = 0;
        do begin
            rev[count] = 4'(v % 10);
            count++;
            v = v / 10;
        end while (v != 0);
        for (int k = 0; k < count; k++) begin
            d.digit_char = btda_pkg::DIGIT_BASE + {2'b00, rev[count - 1 - k]};
            d.last_digit = (k == count - 1);
            digit_queue.push_back(d);
        end
    endfunction

    // Hold tvalid after a transfer; the next call replaces the data or drops tvalid.
    task automatic send_value(input logic [31:0] value);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= value;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_digits(value);
        @(negedge i_clk);
    endtask

    // Receiver stalls in bursts.
    initial begin
        int burst;
        m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (gaps_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                burst = $urandom_range(1, 10);
                repeat (burst) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(negedge i_clk);
        end
    end

    // Check every output transfer.
    always @(posedge i_clk) begin
        t_digit exp_d;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digit_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digit %0d last %0b",
                             m_axis_tdata[btda_pkg::CHAR_W-1:0], m_axis_tlast);
            end else begin
                exp_d = digit_queue.pop_front();
                if (m_axis_tdata[btda_pkg::CHAR_W-1:0] !== exp_d.digit_char
                        || m_axis_tlast !== exp_d.last_digit) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digit mismatch: expected %0d/%0b actual %0d/%0b",
                                 exp_d.digit_char, exp_d.last_digit,
                                 m_axis_tdata[btda_pkg::CHAR_W-1:0], m_axis_tlast);
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("binary_to_decimal_ascii regression: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (digit_queue.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_extremes();
        logic [31:0] pow;
        send_value(32'd0);
        send_value(32'hFFFF_FFFF);
        send_value(32'd1);
        send_value(32'd9);
        pow = 32'd10;
        for (int i = 1; i <= 9; i++) begin
            send_value(pow);
            send_value(pow - 1);
            pow = pow * 10;
        end
        send_value(32'h8000_0000);
        send_value(32'd4000000000);
    endtask

    task automatic test_drain_pause();
        wait_drained();
        send_value(32'd1234567890);
        send_value(32'd5);
    endtask

    task automatic test_random(input int n);
        logic [31:0] v;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: v = $urandom;
                1: v = $urandom_range(0, 999);
                2: v = $urandom >> $urandom_range(0, 31);
                default: v = ~($urandom_range(0, 255));
            endcase
            send_value(v);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        mismatches    = 0;
        idle_cycles   = 0;
        gaps_on       = 1'b1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_extremes();
        test_drain_pause();
        test_random(380);
        gaps_on = 1'b0;
        test_random(70);

        wait_drained();
        repeat (60) @(negedge i_clk);
        if (mismatches == 0 && digit_queue.size() == 0)
            $display("binary_to_decimal_ascii regression: pass");
        else
            $display("binary_to_decimal_ascii regression: fail");
        $finish;
    end
endmodule

// ----- binary_to_decimal_ascii.f -----
hdl/btda_pkg.sv
hdl/btda_stage.sv
hdl/btda_emit.sv
hdl/binary_to_decimal_ascii.sv
tb/tb_binary_to_decimal_ascii.sv
